@@ rtl/core/int_to_radix_text_core_macros.svh @@
// Assertion macros for the radix text converter.
`ifndef INT_TO_RADIX_TEXT_CORE_MACROS_SVH
`define INT_TO_RADIX_TEXT_CORE_MACROS_SVH

// same-cycle implication
`define ITRT_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITRT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/itrt_pkg.sv @@
// Shared types, constants and helpers of the radix text converter.
`default_nettype none

package itrt_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int RADIX_W           = 6;
    localparam int MINW_W            = 6;
    localparam int CHAR_W            = 7;
    localparam int MAX_CHARS_DEFAULT = 64;
    localparam int STORE_CAP         = 64;
    localparam int QUEUE_DEPTH       = 2;
    localparam int BITS_PER_CYCLE    = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]            radix;
        logic [MINW_W-1:0]             min_width;
    } item_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              bad_radix;
    } item_out_t;

    typedef struct packed {
        logic                   bad;
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_W-1:0]     radix;
        logic [MINW_W-1:0]      min_width;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        if (d < 6'd10)
        begin
            return CHAR_ZERO + {1'b0, d};
        end
        return CHAR_LOWA + {1'b0, d} - 7'd10;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/int_to_radix_text_core.sv @@
// Top level of the signed integer to radix text converter.
// Input: start with item (value, radix, min_width); an item is taken on a
//   rising edge with start high and busy low. busy rises when the two-entry
//   command queue is full.
// Output: one character per result, strobe high for exactly one cycle, most
//   significant character first, last set on the final one. A radix outside
//   2..36 gives a single result with bad_radix set and char_code zero.
// Per item: a fetch from the queue, then each digit passes through the
//   shared divider (8 quotient bits per cycle over 32 bits), then one
//   character per cycle out of the digit store through the read and
//   output registers.
// Padding digits do not pass through the divider. The queue lets the next items be
//   taken while the current one converts.
// Reset clears the queue and the engine; no results come out until a new
//   item arrives. The receiver cannot stall results.
`default_nettype none

module int_to_radix_text_core #(
    parameter int MAX_CHARS = itrt_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire itrt_pkg::item_in_t item,
    output logic                    strobe,
    output itrt_pkg::item_out_t     result
);

    itrt_pkg::queue_status_t q_status;
    itrt_pkg::cmd_t          push_cmd;
    itrt_pkg::cmd_t          head_cmd;
    logic                    push;
    logic                    pop;

    itrt_front u_front (
        .start    (start),
        .busy     (busy),
        .item     (item),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    itrt_queue #(
        .DEPTH (itrt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .q_status  (q_status)
    );

    itrt_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head_cmd),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ rtl/core/itrt_front.sv @@
// Front end: takes items and classifies them into commands.
`default_nettype none

module itrt_front (
    input  wire logic                  start,
    output logic                       busy,
    input  wire itrt_pkg::item_in_t    item,
    input  wire itrt_pkg::queue_status_t q_status,
    output logic                       push,
    output itrt_pkg::cmd_t             cmd
);

    logic [itrt_pkg::VALUE_WIDTH-1:0] raw;

    assign raw  = item.value;
    assign busy = q_status.full;
    assign push = start && !q_status.full;

    always_comb
    begin
        cmd.bad       = !(item.radix inside {[itrt_pkg::RADIX_MIN:itrt_pkg::RADIX_MAX]});
        cmd.neg       = raw[itrt_pkg::VALUE_WIDTH-1];
        cmd.mag       = cmd.neg ? (~raw + 1'b1) : raw;
        cmd.radix     = item.radix;
        cmd.min_width = item.min_width;
    end

endmodule

`default_nettype wire

@@ rtl/core/itrt_queue.sv @@
// Short command queue between the front end and the conversion engine.
`default_nettype none

module itrt_queue #(
    parameter int DEPTH = itrt_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire itrt_pkg::cmd_t          push_data,
    input  wire logic                    pop,
    output itrt_pkg::cmd_t               head,
    output itrt_pkg::queue_status_t      q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itrt_pkg::cmd_t   slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/itrt_back.sv @@
// Conversion engine: digit division, digit store and character emission.
`default_nettype none

`include "int_to_radix_text_core_macros.svh"

module itrt_back #(
    parameter int MAX_CHARS = itrt_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire itrt_pkg::queue_status_t q_status,
    input  wire itrt_pkg::cmd_t          head,
    output logic                         pop,
    output logic                         strobe,
    output itrt_pkg::item_out_t          result
);

    localparam int DIGIT_LIMIT = (MAX_CHARS - 1 > itrt_pkg::STORE_CAP) ?
                                 itrt_pkg::STORE_CAP : MAX_CHARS - 1;
    localparam int ADDR_W  = $clog2(DIGIT_LIMIT);
    localparam int CNT_W   = $clog2(DIGIT_LIMIT + 1);
    localparam int BPC     = itrt_pkg::BITS_PER_CYCLE;
    localparam int DIV_W   = ((itrt_pkg::VALUE_WIDTH + BPC - 1) / BPC) * BPC;
    localparam int DIV_CYC = DIV_W / BPC;
    localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int RW      = itrt_pkg::RADIX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RW-1:0]       radix_reg, radix_next;
    logic [itrt_pkg::MINW_W-1:0] minw_reg, minw_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_pad_reg, s1_pad_next;
    logic                s1_last_reg, s1_last_next;
    logic [RW-1:0]       rdata_reg;
    logic                strobe_reg, strobe_next;
    itrt_pkg::item_out_t result_reg, result_next;

    logic [RW-1:0]       mem [DIGIT_LIMIT];
    logic                mem_we;

    logic [RW:0]         trial;
    logic [RW-1:0]       rem_w;
    logic [DIV_W-1:0]    quo_w;
    logic [CNT_W-1:0]    ndig_w;
    logic [CNT_W-1:0]    padt_w;
    logic [CNT_W-1:0]    total_w;

    // eight restoring-division steps per cycle
    always_comb
    begin
        rem_w = rem_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int i = 0; i < BPC; i++)
        begin
            trial = {rem_w, quo_w[DIV_W-1]};
            quo_w = {quo_w[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                rem_w    = RW'(trial - {1'b0, radix_reg});
                quo_w[0] = 1'b1;
            end
            else
            begin
                rem_w = trial[RW-1:0];
            end
        end
    end

    always_comb
    begin
        ndig_w  = (cnt_reg < CNT_W'(DIGIT_LIMIT)) ? cnt_reg + 1'b1 : cnt_reg;
        padt_w  = (CNT_W'(minw_reg) < CNT_W'(DIGIT_LIMIT)) ?
                  CNT_W'(minw_reg) : CNT_W'(DIGIT_LIMIT);
        total_w = (ndig_w > padt_w) ? ndig_w : padt_w;
    end

    always_comb
    begin
        state_next    = state_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        radix_next    = radix_reg;
        minw_next     = minw_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        s1_valid_next = 1'b0;
        s1_pad_next   = s1_pad_reg;
        s1_last_next  = s1_last_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;

        if (s1_valid_reg)
        begin
            strobe_next           = 1'b1;
            result_next.char_code = s1_pad_reg ? itrt_pkg::CHAR_ZERO
                                               : itrt_pkg::digit_char(rdata_reg);
            result_next.last      = s1_last_reg;
            result_next.bad_radix = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && !s1_valid_reg)
                begin
                    pop = 1'b1;
                    if (head.bad)
                    begin
                        strobe_next           = 1'b1;
                        result_next.char_code = itrt_pkg::CHAR_NONE;
                        result_next.last      = 1'b1;
                        result_next.bad_radix = 1'b1;
                    end
                    else
                    begin
                        quo_next   = DIV_W'(head.mag);
                        rem_next   = '0;
                        step_next  = '0;
                        radix_next = head.radix;
                        minw_next  = head.min_width;
                        neg_next   = head.neg;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next  = quo_w;
                rem_next  = rem_w;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_CYC - 1))
                begin
                    mem_we    = (cnt_reg < CNT_W'(DIGIT_LIMIT));
                    cnt_next  = ndig_w;
                    rem_next  = '0;
                    step_next = '0;
                    if (quo_w == '0)
                    begin
                        idx_next   = total_w - 1'b1;
                        state_next = ST_EMIT;
                        if (neg_reg)
                        begin
                            strobe_next           = 1'b1;
                            result_next.char_code = itrt_pkg::CHAR_MINUS;
                            result_next.last      = 1'b0;
                            result_next.bad_radix = 1'b0;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                s1_valid_next = 1'b1;
                s1_pad_next   = (idx_reg >= cnt_reg);
                s1_last_next  = (idx_reg == '0);
                idx_next      = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            quo_reg      <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            radix_reg    <= '0;
            minw_reg     <= '0;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_pad_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            quo_reg      <= quo_next;
            rem_reg      <= rem_next;
            step_reg     <= step_next;
            radix_reg    <= radix_next;
            minw_reg     <= minw_next;
            neg_reg      <= neg_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= s1_valid_next;
            s1_pad_reg   <= s1_pad_next;
            s1_last_reg  <= s1_last_next;
            strobe_reg   <= strobe_next;
            result_reg   <= result_next;
        end
    end

    // digit store, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= rem_w;
        end
        rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `ITRT_ASSERT_NOW(a_bad_is_single, clk, rst_n, strobe_reg && result_reg.bad_radix, result_reg.last && (result_reg.char_code == itrt_pkg::CHAR_NONE), "bad radix result malformed")
    `ITRT_ASSERT_NEXT(a_last_reaches_port, clk, rst_n, s1_valid_reg && s1_last_reg, strobe_reg && result_reg.last && !result_reg.bad_radix, "final character lost")
    `ITRT_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DIGIT_LIMIT), "digit count past store limit")
    `ITRT_ASSERT_NOW(a_idx_bound, clk, rst_n, state_reg == ST_EMIT, idx_reg < CNT_W'(DIGIT_LIMIT), "emit index past store limit")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for int_to_radix_text_core: queued driver, result monitor, text predictor.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        itrt_pkg::item_in_t req;
        bit                 drain;
    } text_req_t;

    localparam int NUM_RANDOM = 198;
    localparam int QUIET_TAIL = 40;
    localparam int DIGIT_CAP  = itrt_pkg::MAX_CHARS_DEFAULT - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    itrt_pkg::item_in_t  item = '0;
    logic                strobe;
    itrt_pkg::item_out_t result;

    text_req_t           pending_reqs[$];
    itrt_pkg::item_out_t expected_chars[$];
    int                  total_reqs = 0;
    int                  sent_count = 0;
    int                  gap_left = 0;
    int                  errors = 0;

    int_to_radix_text_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 100)
        begin
            $display("tb: mismatch at %0t: %s", $time, msg);
        end
    endtask

    // expected characters of one number, most significant first
    task automatic predict_text(input itrt_pkg::item_in_t req);
        logic [itrt_pkg::VALUE_WIDTH-1:0] mag;
        logic [5:0]                       digits[DIGIT_CAP];
        logic [5:0]                       d;
        logic                             neg;
        int                               n;
        itrt_pkg::item_out_t              ch;
        n = 0;
        if (req.radix < itrt_pkg::RADIX_MIN || req.radix > itrt_pkg::RADIX_MAX)
        begin
            ch.char_code = itrt_pkg::CHAR_NONE;
            ch.last      = 1'b1;
            ch.bad_radix = 1'b1;
            expected_chars.push_back(ch);
            return;
        end
        neg = req.value[itrt_pkg::VALUE_WIDTH-1];
        mag = req.value;
        if (neg)
        begin
            mag = ~mag + 1'b1;
        end
        do
        begin
            if (n < DIGIT_CAP)
            begin
                digits[n] = 6'(mag % req.radix);
                n++;
            end
            mag = mag / req.radix;
        end
        while (mag != 0);
        while (n < req.min_width && n < DIGIT_CAP)
        begin
            digits[n] = 6'd0;
            n++;
        end
        ch.bad_radix = 1'b0;
        if (neg)
        begin
            ch.char_code = itrt_pkg::CHAR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            d = digits[k];
            if (d < 6'd10)
            begin
                ch.char_code = itrt_pkg::CHAR_ZERO + 7'(d);
            end
            else
            begin
                ch.char_code = itrt_pkg::CHAR_LOWA + 7'(d) - 7'd10;
            end
            ch.last = (k == 0);
            expected_chars.push_back(ch);
        end
    endtask

    task automatic queue_req(input logic [31:0] v, input int rdx, input int mw,
                             input bit drain);
        text_req_t t;
        t.req.value     = v;
        t.req.radix     = 6'(rdx);
        t.req.min_width = 6'(mw);
        t.drain         = drain;
        pending_reqs.push_back(t);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 40);
            1: v = -$urandom_range(1, 40);
            2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: v = $urandom & ((32'h1 << $urandom_range(1, 31)) - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // sender: holds start with the item until taken
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_start;
        bit   idle_ok;
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else
        begin
            nxt_start = start;
            idle_ok   = sent_count < total_reqs - QUIET_TAIL;
            if (start && !busy)
            begin
                predict_text(item);
                sent_count++;
                nxt_start = 1'b0;
                if (idle_ok && $urandom_range(0, 5) == 0)
                begin
                    gap_left <= $urandom_range(1, 16);
                end
            end
            else if (!start)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_chars.size() != 0))
                begin
                    if (idle_ok && $urandom_range(0, 9) == 0)
                    begin
                        gap_left <= $urandom_range(1, 16);
                    end
                    else
                    begin
                        item <= pending_reqs[0].req;
                        void'(pending_reqs.pop_front());
                        nxt_start = 1'b1;
                    end
                end
            end
            start <= nxt_start;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        itrt_pkg::item_out_t want;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result char=%02h last=%b bad=%b",
                                        result.char_code, result.last, result.bad_radix));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (result.char_code !== want.char_code)
                begin
                    flag_mismatch($sformatf("char_code %02h, want %02h",
                                            result.char_code, want.char_code));
                end
                if (result.last !== want.last)
                begin
                    flag_mismatch($sformatf("last %b, want %b", result.last, want.last));
                end
                if (result.bad_radix !== want.bad_radix)
                begin
                    flag_mismatch($sformatf("bad_radix %b, want %b",
                                            result.bad_radix, want.bad_radix));
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int rdx;
        int mw;
        queue_req(32'd0, 10, 0, 0);
        queue_req(32'd0, 2, 63, 0);
        queue_req(32'h8000_0000, 2, 0, 0);
        queue_req(32'h8000_0000, 16, 0, 0);
        queue_req(32'h7fff_ffff, 2, 0, 0);
        queue_req(32'h7fff_ffff, 36, 0, 0);
        queue_req(-32'sd1, 36, 0, 0);
        queue_req(32'd35, 36, 1, 0);
        queue_req(32'd12345, 0, 5, 0);
        queue_req(32'd12345, 1, 5, 0);
        queue_req(-32'sd7, 37, 0, 1);
        queue_req(32'hffff_ffff, 63, 63, 0);
        queue_req(-32'sd123, 10, 63, 0);
        queue_req(32'd255, 16, 8, 0);
        queue_req(32'd1000, 10, 3, 0);
        queue_req(-32'sd1000, 10, 4, 1);
        queue_req(32'd100, 3, 0, 0);
        queue_req(32'd511, 8, 2, 0);
        queue_req(32'd48, 7, 0, 0);
        queue_req(32'h2aaa_aaaa, 35, 0, 0);
        queue_req(32'h5555_5555, 2, 33, 0);
        queue_req(32'h7fff_ffff, 10, 0, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            rdx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                                      : $urandom_range(37, 63))
                                               : $urandom_range(2, 36);
            mw  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
            queue_req(pick_value(), rdx, mw, (i == NUM_RANDOM / 2));
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_reqs) @(posedge clk);
        for (int c = 0; c < 20000 && expected_chars.size() != 0; c++) @(posedge clk);
        repeat (300) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected results never came",
                                    expected_chars.size()));
        end

        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/itrt_pkg.sv
rtl/core/itrt_front.sv
rtl/core/itrt_queue.sv
rtl/core/itrt_back.sv
rtl/core/int_to_radix_text_core.sv
tb/sv/tb_top.sv
